[hw/rtl/record_sort_by_key_descending_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the record sort block
// Same-cycle and next-cycle implication checks, clocked on clk and held off
// while rst_n is low. Empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef RECORD_SORT_BY_KEY_DESCENDING_ASSERT_SVH
`define RECORD_SORT_BY_KEY_DESCENDING_ASSERT_SVH

`ifndef SYNTH

// Antecedent implies consequent in the same cycle
`define RSORT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define RSORT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RSORT_ASSERT_IMP(lbl, ante, cons, msg)
`define RSORT_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/rsort_pkg.sv]
// ---------------------------------------------------------------------------
// rsort_pkg
// Widths and defaults shared by the record sort block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsort_pkg;

  // Record fields
  localparam int KEY_W = 32;
  localparam int ID_W  = 16;
  localparam int REC_W = KEY_W + ID_W;

  // Stream data width, padded to whole bytes
  localparam int DATA_W = ((REC_W + 7) / 8) * 8;

  // Default batch capacity
  localparam int MAX_RECORDS_DEF = 64;

endpackage

[hw/rtl/record_sort_by_key_descending.sv]
// ---------------------------------------------------------------------------
// record_sort_by_key_descending
// Stable descending bubble sort of a record batch held in one record RAM.
// Load: one input transaction per cycle. Sort of n records: start read, then per
// pass e = n-1 .. 1: first read, e compare-and-writes (one a cycle), end write.
// Output: a read waits for the last to land; no input during sort and output.
// Synchronous active-low reset empties the batch and output register; RAM is kept.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "record_sort_by_key_descending_assert.svh"

module record_sort_by_key_descending #(
  parameter int MAX_RECORDS = rsort_pkg::MAX_RECORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [rsort_pkg::DATA_W-1:0] in_tdata,   // [31:0] key_value, [47:32] record_id
  input  logic                         in_tlast,   // batch_end
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [rsort_pkg::DATA_W-1:0] out_tdata,  // [31:0] sorted_key, [47:32] sorted_id
  output logic                         out_tlast,  // run_last
  output logic                         out_tuser   // overflow
);

  import rsort_pkg::*;

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_FIRST,
    S_CMP,
    S_PASS_END,
    S_OUT
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic              drop_r;
  logic [AW-1:0]     end_r;
  logic [AW-1:0]     pos_r;
  logic [REC_W-1:0]  car_r;
  logic [AW-1:0]     idx_r;
  logic              pend_r;
  logic              pend_last_r;
  logic              pend_flag_r;
  logic              ov_r;
  logic [REC_W-1:0]  od_r;
  logic              olast_r;
  logic              oflag_r;

  logic              in_acc;
  logic              has_room;
  logic              car_lt;
  logic              issue;
  logic              last_idx;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [REC_W-1:0]  wr_data;
  logic [AW-1:0]     rd_addr;
  logic [REC_W-1:0]  rd_data;

  // Record store
  rsort_ram #(
    .DATA_W (REC_W),
    .DEPTH  (MAX_RECORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Handshake and compare terms
  assign in_tready = (state_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign has_room  = (cnt_r != MAX_CNT);
  assign cnt_nxt   = has_room ? cnt_r + CW'(1) : cnt_r;
  assign car_lt    = $signed(car_r[KEY_W-1:0]) < $signed(rd_data[KEY_W-1:0]);
  assign issue     = (state_r == S_OUT) && !pend_r && (!ov_r || out_tready);
  assign last_idx  = (CW'(idx_r) == cnt_r - CW'(1));

  // Steer RAM ports
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = car_r;
    rd_addr = idx_r;
    unique case (state_r)
      S_LOAD: begin
        wr_en   = in_acc && has_room;
        wr_addr = cnt_r[AW-1:0];
        wr_data = in_tdata[REC_W-1:0];
      end
      S_START: begin
        rd_addr = '0;
      end
      S_FIRST: begin
        rd_addr = AW'(1);
      end
      S_CMP: begin
        // Larger key settles at pos; on a tie the earlier (carried) record settles
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = car_lt ? rd_data : car_r;
        rd_addr = pos_r + AW'(2);
      end
      S_PASS_END: begin
        wr_en   = 1'b1;
        wr_addr = end_r;
        wr_data = car_r;
        rd_addr = '0;
      end
      S_OUT: begin
        rd_addr = idx_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer, batch state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      end_r       <= '0;
      pos_r       <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      pend_flag_r <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      // Drain output register, then land a pending read
      if (ov_r && out_tready) begin
        ov_r <= 1'b0;
      end
      if (pend_r) begin
        od_r    <= rd_data;
        olast_r <= pend_last_r;
        oflag_r <= pend_flag_r;
        ov_r    <= 1'b1;
        pend_r  <= 1'b0;
      end

      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            cnt_r <= cnt_nxt;
            if (!has_room) begin
              drop_r <= 1'b1;
            end
            if (in_tlast) begin
              end_r <= AW'(cnt_nxt - CW'(1));
              idx_r <= '0;
              if (cnt_nxt > CW'(1)) begin
                state_r <= S_START;
              end else begin
                state_r <= S_OUT;
              end
            end
          end
        end
        S_START: begin
          state_r <= S_FIRST;
        end
        S_FIRST: begin
          car_r   <= rd_data;
          pos_r   <= '0;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (!car_lt) begin
            car_r <= rd_data;
          end
          if (pos_r + AW'(1) == end_r) begin
            state_r <= S_PASS_END;
          end else begin
            pos_r <= pos_r + AW'(1);
          end
        end
        S_PASS_END: begin
          end_r <= end_r - AW'(1);
          if (end_r == AW'(1)) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_FIRST;
          end
        end
        S_OUT: begin
          if (issue) begin
            pend_r      <= 1'b1;
            pend_last_r <= last_idx;
            pend_flag_r <= drop_r;
            if (last_idx) begin
              state_r <= S_LOAD;
              cnt_r   <= '0;
              drop_r  <= 1'b0;
            end else begin
              idx_r <= idx_r + AW'(1);
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  // Drive result channel
  assign out_tvalid = ov_r;
  assign out_tdata  = DATA_W'(od_r);
  assign out_tlast  = olast_r;
  assign out_tuser  = oflag_r;

  `RSORT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= MAX_CNT, "record count above capacity")
  `RSORT_ASSERT_IMP(a_cmp_pos, state_r == S_CMP, pos_r < end_r, "compare past pass end")
  `RSORT_ASSERT_IMP(a_no_wr_out, state_r == S_OUT, !wr_en, "store written during output")
  `RSORT_ASSERT_NXT(a_last_stops, in_acc && in_tlast, !in_tready, "input open after batch end")
  `RSORT_ASSERT_NXT(a_pend_lands, pend_r, ov_r, "pending read did not reach output")

endmodule

[hw/rtl/rsort_ram.sv]
// ---------------------------------------------------------------------------
// rsort_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsort_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
